@@ rtl/core/fspa_pkg.sv @@
package fspa_pkg;

    localparam int BLOCK_ELEMS_DEF   = 16;
    localparam int MAX_BLOCKS_DEF    = 16;
    localparam int DEFAULT_ALIGN_DEF = 4;

    // element indices are 8 bits, so the link store always has 256 entries
    localparam int ELEM_W     = 8;
    localparam int LINK_DEPTH = 256;
    localparam int LINK_W     = ELEM_W + 1;

    localparam int SIZE_W  = 13;
    localparam int BCFG_W  = 5;
    localparam int CIDX_W  = 2;
    localparam int USED_W  = 9;
    localparam int CAPO_W  = 9;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_RESET = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EXHAUSTED = 3'd1;
    localparam logic [2:0] ST_BAD_HANDLE = 3'd2;
    localparam logic [2:0] ST_TOO_BIG   = 3'd3;
    localparam logic [2:0] ST_IN_USE    = 3'd4;

    localparam logic [CIDX_W-1:0] CFG_ELEM_SIZE      = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_ELEM_ALIGN     = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_INITIAL_BLOCKS = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_GROWTH_BLOCKS  = 2'd3;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [ELEM_W-1:0] handle;
        logic [SIZE_W-1:0] request_size;
        logic              restore_initial;
    } fspa_in_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [ELEM_W-1:0] alloc_handle;
        logic [USED_W-1:0] used_count;
        logic [BCFG_W-1:0] block_count;
        logic [CAPO_W-1:0] capacity;
    } fspa_out_t;

endpackage

@@ rtl/core/fspa_ram.sv @@
module fspa_ram
#(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/fixed_size_pool_allocator.sv @@
// Free, reset in use, size too big and exhausted pass S_EXEC and S_OUT from transfer to result;
// a plain allocate also passes S_RD and S_POP (link store read is registered).
// Growth and pool reset push each element in S_PUSH: BLOCK_ELEMS per block, one link write each.
// A new command is taken only back in S_IDLE; pushes and output stalls delay its acceptance.
// After rst_n the pool is empty and the link store holds no valid data; issue a pool reset with
// restore to build the initial free list.
module fixed_size_pool_allocator
    import fspa_pkg::*;
#(
    parameter int BLOCK_ELEMS   = BLOCK_ELEMS_DEF,
    parameter int MAX_BLOCKS    = MAX_BLOCKS_DEF,
    parameter int DEFAULT_ALIGN = DEFAULT_ALIGN_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  fspa_in_t          in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output fspa_out_t         out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0] cfg_data
);

    // block count must hold MAX_BLOCKS and any 5-bit initial/growth sum
    localparam int BLK_W   = $clog2(MAX_BLOCKS + 32);
    localparam int CAP_RAW = BLK_W + $clog2(BLOCK_ELEMS + 1);
    localparam int CAP_W   = (CAP_RAW < 9) ? 9 : CAP_RAW;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_PUSH = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_POP  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]        state_reg, state_next;
    fspa_in_t          cmd_reg, cmd_next;
    logic [2:0]        status_reg, status_next;
    logic [ELEM_W-1:0] got_reg, got_next;

    logic [SIZE_W-1:0] elem_size_reg;
    logic [SIZE_W-1:0] elem_align_reg;
    logic [BCFG_W-1:0] initial_blocks_reg;
    logic [BCFG_W-1:0] growth_blocks_reg;

    logic [ELEM_W-1:0] head_reg, head_next;
    logic              nonempty_reg, nonempty_next;
    logic [USED_W-1:0] used_reg, used_next;
    logic [BLK_W-1:0]  blocks_reg, blocks_next;
    logic [ELEM_W-1:0] elem_reg, elem_next;
    logic [CAP_W-1:0]  remain_reg, remain_next;

    logic              out_valid_reg, out_valid_next;
    fspa_out_t         out_reg, out_next;

    logic              ram_we;
    logic [ELEM_W-1:0] ram_waddr;
    logic [LINK_W-1:0] ram_wdata;
    logic [LINK_W-1:0] ram_rdata;

    logic [SIZE_W-1:0] align_eff;
    logic [SIZE_W:0]   align_m1;
    logic [SIZE_W:0]   aligned_size;
    logic [BLK_W-1:0]  grow_sum;
    logic [BLK_W-1:0]  grow_target;
    logic [BLK_W-1:0]  restore_blocks;
    logic [BLK_W-1:0]  rebuild_blocks;
    logic [CAP_W-1:0]  cap_full;
    logic              out_free;

    fspa_ram
    #(
        .WIDTH (LINK_W),
        .DEPTH (LINK_DEPTH)
    )
    u_link_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        align_eff    = (elem_align_reg == '0) ? SIZE_W'(DEFAULT_ALIGN) : elem_align_reg;
        align_m1     = {1'b0, align_eff} - (SIZE_W+1)'(1);
        aligned_size = ({1'b0, elem_size_reg} + align_m1) & ~align_m1;

        grow_sum    = blocks_reg + BLK_W'(growth_blocks_reg);
        grow_target = (grow_sum > BLK_W'(MAX_BLOCKS)) ? BLK_W'(MAX_BLOCKS) : grow_sum;

        restore_blocks = (BLK_W'(initial_blocks_reg) > BLK_W'(MAX_BLOCKS)) ?
                         BLK_W'(MAX_BLOCKS) : BLK_W'(initial_blocks_reg);
        rebuild_blocks = cmd_reg.restore_initial ? restore_blocks : blocks_reg;

        cap_full = CAP_W'(blocks_reg) * CAP_W'(BLOCK_ELEMS);
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        status_next    = status_reg;
        got_next       = got_reg;
        head_next      = head_reg;
        nonempty_next  = nonempty_reg;
        used_next      = used_reg;
        blocks_next    = blocks_reg;
        elem_next      = elem_reg;
        remain_next    = remain_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_waddr      = elem_reg;
        ram_wdata      = {!nonempty_reg, head_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next    = in_data;
                    status_next = ST_OK;
                    got_next    = '0;
                    state_next  = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_OUT;
                case (cmd_reg.cmd)
                    CMD_ALLOC:
                    begin
                        if ({1'b0, cmd_reg.request_size} > aligned_size)
                        begin
                            status_next = ST_TOO_BIG;
                        end
                        else if (nonempty_reg)
                        begin
                            state_next = S_RD;
                        end
                        else if (grow_target > blocks_reg)
                        begin
                            elem_next   = ELEM_W'(cap_full);
                            remain_next = CAP_W'(grow_target - blocks_reg) * CAP_W'(BLOCK_ELEMS);
                            blocks_next = grow_target;
                            state_next  = S_PUSH;
                        end
                        else
                        begin
                            status_next = ST_EXHAUSTED;
                        end
                    end

                    CMD_FREE:
                    begin
                        if (CAP_W'(cmd_reg.handle) >= cap_full)
                        begin
                            status_next = ST_BAD_HANDLE;
                        end
                        else
                        begin
                            ram_we        = 1'b1;
                            ram_waddr     = cmd_reg.handle;
                            head_next     = cmd_reg.handle;
                            nonempty_next = 1'b1;
                            if (used_reg != '0)
                            begin
                                used_next = used_reg - USED_W'(1);
                            end
                        end
                    end

                    CMD_RESET:
                    begin
                        if (used_reg != '0)
                        begin
                            status_next = ST_IN_USE;
                        end
                        else
                        begin
                            blocks_next   = rebuild_blocks;
                            head_next     = '0;
                            nonempty_next = 1'b0;
                            elem_next     = '0;
                            remain_next   = CAP_W'(rebuild_blocks) * CAP_W'(BLOCK_ELEMS);
                            if (rebuild_blocks != '0)
                            begin
                                state_next = S_PUSH;
                            end
                        end
                    end

                    default:
                    begin
                        status_next = ST_OK;
                    end
                endcase
            end

            S_PUSH:
            begin
                ram_we        = 1'b1;
                head_next     = elem_reg;
                nonempty_next = 1'b1;
                elem_next     = elem_reg + ELEM_W'(1);
                remain_next   = remain_reg - CAP_W'(1);
                if (remain_reg == CAP_W'(1))
                begin
                    state_next = (cmd_reg.cmd == CMD_ALLOC) ? S_RD : S_OUT;
                end
            end

            S_RD:
            begin
                // link of the head is read this cycle, available next
                state_next = S_POP;
            end

            S_POP:
            begin
                got_next      = head_reg;
                nonempty_next = !ram_rdata[ELEM_W];
                head_next     = ram_rdata[ELEM_W-1:0];
                if (used_reg != '1)
                begin
                    used_next = used_reg + USED_W'(1);
                end
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.status       = status_reg;
                    out_next.alloc_handle = got_reg;
                    out_next.used_count   = used_reg;
                    out_next.block_count  = BCFG_W'(blocks_reg);
                    out_next.capacity     = CAPO_W'(cap_full);
                    state_next            = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            head_reg           <= '0;
            nonempty_reg       <= 1'b0;
            used_reg           <= '0;
            blocks_reg         <= '0;
            remain_reg         <= '0;
            out_valid_reg      <= 1'b0;
            elem_size_reg      <= SIZE_W'(4);
            elem_align_reg     <= '0;
            initial_blocks_reg <= BCFG_W'(1);
            growth_blocks_reg  <= BCFG_W'(1);
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            nonempty_reg  <= nonempty_next;
            used_reg      <= used_next;
            blocks_reg    <= blocks_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_ELEM_SIZE:      elem_size_reg      <= cfg_data;
                    CFG_ELEM_ALIGN:     elem_align_reg     <= cfg_data;
                    CFG_INITIAL_BLOCKS: initial_blocks_reg <= cfg_data[BCFG_W-1:0];
                    CFG_GROWTH_BLOCKS:  growth_blocks_reg  <= cfg_data[BCFG_W-1:0];
                    default:            elem_size_reg      <= elem_size_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        status_reg <= status_next;
        got_reg    <= got_next;
        elem_reg   <= elem_next;
        out_reg    <= out_next;
    end

endmodule
